/* rtl/core/hxc_pkg.sv */
package hxc_pkg;

    localparam int DEF_MAX_NODES = 256;
    localparam int DEF_FRAC_BITS = 16;

    localparam int ID_W      = 8;
    localparam int ELEM_W    = 4;
    localparam int VAL_W     = 32;
    localparam int CFG_IDX_W = 2;
    localparam int NUM_ELEM  = 16;
    localparam int MAC_CNT_W = 6;

    localparam logic [ELEM_W-1:0]    LAST_ELEM    = 4'd15;
    localparam logic [MAC_CNT_W-1:0] LAST_MAC     = 6'd63;

    localparam logic [CFG_IDX_W-1:0] CFG_SHIFT_X = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SHIFT_Y = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SHIFT_Z = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_WAIT,
        ST_WB
    } state_t;

    typedef struct packed {
        logic              vld;
        logic              first;
        logic              last;
        logic [ELEM_W-1:0] elem;
    } mac_ctl_t;

endpackage

/* rtl/core/hxc_mac.sv */
module hxc_mac #(
    parameter int FRAC_BITS = hxc_pkg::DEF_FRAC_BITS
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                en,
    input  hxc_pkg::mac_ctl_t                   ctl,
    input  logic signed [hxc_pkg::VAL_W-1:0]    p_val,
    input  logic signed [hxc_pkg::VAL_W-1:0]    l_val,
    output logic                                res_vld,
    output logic        [hxc_pkg::ELEM_W-1:0]   res_elem,
    output logic signed [hxc_pkg::VAL_W-1:0]    res_val
);
    import hxc_pkg::*;

    localparam int PROD_W = 2 * VAL_W;
    localparam int ACC_W  = PROD_W + 2;

    localparam logic signed [ACC_W-1:0] SAT_HI =
        {{(ACC_W - VAL_W){1'b0}}, 1'b0, {(VAL_W - 1){1'b1}}};
    localparam logic signed [ACC_W-1:0] SAT_LO =
        {{(ACC_W - VAL_W){1'b1}}, 1'b1, {(VAL_W - 1){1'b0}}};

    logic signed [PROD_W-1:0] prod_reg;
    mac_ctl_t                 prod_ctl_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    logic                     acc_vld_reg;
    logic [ELEM_W-1:0]        acc_elem_reg;
    logic signed [ACC_W-1:0]  acc_shift;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_ctl_reg <= '0;
            acc_vld_reg  <= 1'b0;
        end
        else if (en)
        begin
            prod_ctl_reg <= ctl;
            acc_vld_reg  <= prod_ctl_reg.vld && prod_ctl_reg.last;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg <= PROD_W'(p_val) * PROD_W'(l_val);
            if (prod_ctl_reg.vld)
            begin
                // exact four-term sum, rounding happens once at the end
                if (prod_ctl_reg.first)
                    acc_reg <= ACC_W'(prod_reg);
                else
                    acc_reg <= acc_reg + ACC_W'(prod_reg);
                acc_elem_reg <= prod_ctl_reg.elem;
            end
        end
    end

    always_comb
    begin
        acc_shift = acc_reg >>> FRAC_BITS;
        if (acc_shift > SAT_HI)
            res_val = SAT_HI[VAL_W-1:0];
        else if (acc_shift < SAT_LO)
            res_val = SAT_LO[VAL_W-1:0];
        else
            res_val = acc_shift[VAL_W-1:0];
    end

    assign res_vld  = acc_vld_reg;
    assign res_elem = acc_elem_reg;

endmodule

/* rtl/core/hierarchical_transform_compose.sv */
// Forward kinematics over an ordered bone tree in signed Q16.16 (FRAC_BITS fraction
// bits). Local matrix elements stream in one per transfer; elements 0..14 are taken
// every cycle. Element 15 starts the compute world = P * local, where P is the root
// matrix (identity plus the configured translation) or the parent's stored world
// matrix. One shared 32x32 multiplier does one product per cycle unless out_stall
// freezes it: 64 multiply-accumulate steps per node, then 16 write-backs if a node
// names itself as parent. Element 15 of the next node is held off with in_stall until
// the compute and any write-back are done. World matrices live in a MAX_NODES*16 x 32
// memory with one read port and one write port; each result is written as it is
// produced (a self-parent node's at the end). Results saturate to 32 bits and are
// emitted in index order, out_last marking element 15. Parents must precede children.
module hierarchical_transform_compose #(
    parameter int MAX_NODES = hxc_pkg::DEF_MAX_NODES,
    parameter int FRAC_BITS = hxc_pkg::DEF_FRAC_BITS
) (
    input  logic                                 clk,
    input  logic                                 rst_n,

    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic        [hxc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic        [hxc_pkg::VAL_W-1:0]     cfg_data,

    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic        [hxc_pkg::ID_W-1:0]      node_id,
    input  logic        [hxc_pkg::ID_W-1:0]      parent_id,
    input  logic                                 is_root,
    input  logic        [hxc_pkg::ELEM_W-1:0]    elem_index,
    input  logic signed [hxc_pkg::VAL_W-1:0]     elem_value,

    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic        [hxc_pkg::ID_W-1:0]      out_node,
    output logic        [hxc_pkg::ELEM_W-1:0]    out_index,
    output logic signed [hxc_pkg::VAL_W-1:0]     out_value,
    output logic                                 out_last
);
    import hxc_pkg::*;

    localparam int NID_W  = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
    localparam int XID_W  = ((NID_W > ID_W) ? NID_W : ID_W) + 1;
    localparam int ADDR_W = NID_W + ELEM_W;
    localparam int DEPTH  = MAX_NODES * NUM_ELEM;

    localparam logic [VAL_W-1:0] P_ONE = VAL_W'(64'd1 << FRAC_BITS);

    state_t                   state_reg, state_next;
    logic [MAC_CNT_W-1:0]     cnt_reg;
    logic [ELEM_W-1:0]        wb_cnt_reg;

    logic [VAL_W-1:0]         shift_reg [3];
    logic [VAL_W-1:0]         local_reg [NUM_ELEM];
    logic [VAL_W-1:0]         snap_reg  [NUM_ELEM];
    logic [VAL_W-1:0]         res_reg   [NUM_ELEM];

    logic [ID_W-1:0]          node_reg;
    logic [NID_W-1:0]         node_addr_reg;
    logic [NID_W-1:0]         par_addr_reg;
    logic                     root_reg;
    logic                     par_ok_reg;
    logic                     node_ok_reg;
    logic                     self_reg;

    logic                     s1_vld_reg;
    logic [1:0]               s1_k_reg;
    logic [ELEM_W-1:0]        s1_e_reg;
    logic signed [VAL_W-1:0]  s1_l_reg;
    logic [VAL_W-1:0]         rd_data_reg;

    logic [VAL_W-1:0]         world_mem [DEPTH];

    logic [ID_W-1:0]          out_node_reg;
    logic [ELEM_W-1:0]        out_index_reg;
    logic [VAL_W-1:0]         out_value_reg;
    logic                     out_valid_reg;

    logic [XID_W-1:0]         node_x;
    logic [XID_W-1:0]         par_x;
    logic                     node_ok;
    logic                     par_ok;

    logic                     in_acc;
    logic                     start;
    logic                     freeze;
    logic                     issue;
    logic                     load;
    logic                     out_take;

    logic [ELEM_W-1:0]        p_idx;
    logic [ELEM_W-1:0]        l_idx;
    logic [ADDR_W-1:0]        rd_addr;
    logic                     wr_en;
    logic [ADDR_W-1:0]        wr_addr;
    logic [VAL_W-1:0]         wr_data;

    mac_ctl_t                 mac_ctl;
    logic signed [VAL_W-1:0]  p_val;
    logic                     res_vld;
    logic [ELEM_W-1:0]        res_elem;
    logic signed [VAL_W-1:0]  res_val;

    assign cfg_ready = 1'b1;

    assign node_x  = XID_W'(node_id);
    assign par_x   = XID_W'(parent_id);
    assign node_ok = node_x < XID_W'(MAX_NODES);
    assign par_ok  = par_x < XID_W'(MAX_NODES);

    assign in_stall = in_valid && (elem_index == LAST_ELEM) && (state_reg != ST_IDLE);
    assign in_acc   = in_valid && !in_stall;
    assign start    = in_acc && (elem_index == LAST_ELEM);

    assign freeze   = out_valid_reg && out_stall;
    assign issue    = (state_reg == ST_RUN) && !freeze;
    assign load     = res_vld && !freeze;
    assign out_take = out_valid_reg && !out_stall;

    // count = {column, row, k}
    assign p_idx   = {cnt_reg[1:0], cnt_reg[3:2]};
    assign l_idx   = {cnt_reg[5:4], cnt_reg[1:0]};
    assign rd_addr = {par_addr_reg, p_idx};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shift_reg[0] <= '0;
            shift_reg[1] <= '0;
            shift_reg[2] <= '0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_SHIFT_X: shift_reg[0] <= cfg_data;
                CFG_SHIFT_Y: shift_reg[1] <= cfg_data;
                CFG_SHIFT_Z: shift_reg[2] <= cfg_data;
                default:     ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
            local_reg[elem_index] <= elem_value;
        if (start)
        begin
            for (int i = 0; i < NUM_ELEM - 1; i++)
                snap_reg[i] <= local_reg[i];
            snap_reg[NUM_ELEM-1] <= elem_value;
            node_reg      <= node_id;
            node_addr_reg <= node_x[NID_W-1:0];
            par_addr_reg  <= par_ok ? par_x[NID_W-1:0] : '0;
            root_reg      <= is_root;
            par_ok_reg    <= par_ok;
            node_ok_reg   <= node_ok;
            self_reg      <= !is_root && (parent_id == node_id) && node_ok;
        end
        if (load)
            res_reg[res_elem] <= res_val;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                    state_next = ST_RUN;
            end
            ST_RUN:
            begin
                if (issue && (cnt_reg == LAST_MAC))
                    state_next = ST_WAIT;
            end
            ST_WAIT:
            begin
                if (load && (res_elem == LAST_ELEM))
                    state_next = self_reg ? ST_WB : ST_IDLE;
            end
            ST_WB:
            begin
                if (wb_cnt_reg == LAST_ELEM)
                    state_next = ST_IDLE;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg    <= '0;
            wb_cnt_reg <= '0;
            s1_vld_reg <= 1'b0;
        end
        else
        begin
            if (start)
                cnt_reg <= '0;
            else if (issue)
                cnt_reg <= cnt_reg + 1'b1;

            if (state_reg == ST_WB)
                wb_cnt_reg <= wb_cnt_reg + 1'b1;
            else
                wb_cnt_reg <= '0;

            if (!freeze)
                s1_vld_reg <= issue;
        end
    end

    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            s1_k_reg <= cnt_reg[1:0];
            s1_e_reg <= cnt_reg[5:2];
            s1_l_reg <= snap_reg[l_idx];
        end
    end

    // self-parent results are held back until every read of the old matrix is done
    assign wr_en   = (load && node_ok_reg && !self_reg) || (state_reg == ST_WB);
    assign wr_addr = {node_addr_reg, (state_reg == ST_WB) ? wb_cnt_reg : res_elem};
    assign wr_data = (state_reg == ST_WB) ? res_reg[wb_cnt_reg] : res_val;

    always_ff @(posedge clk)
    begin
        if (wr_en)
            world_mem[wr_addr] <= wr_data;
        if (issue)
            rd_data_reg <= world_mem[rd_addr];
    end

    always_comb
    begin
        p_val = '0;
        if (root_reg)
        begin
            if (s1_k_reg == s1_e_reg[1:0])
                p_val = P_ONE;
            else if (s1_k_reg == 2'd3)
            begin
                case (s1_e_reg[1:0])
                    2'd0:    p_val = shift_reg[0];
                    2'd1:    p_val = shift_reg[1];
                    2'd2:    p_val = shift_reg[2];
                    default: p_val = '0;
                endcase
            end
        end
        else if (par_ok_reg)
            p_val = rd_data_reg;
    end

    always_comb
    begin
        mac_ctl.vld   = s1_vld_reg;
        mac_ctl.first = s1_k_reg == 2'd0;
        mac_ctl.last  = s1_k_reg == 2'd3;
        mac_ctl.elem  = s1_e_reg;
    end

    hxc_mac #(
        .FRAC_BITS (FRAC_BITS)
    ) u_mac (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (!freeze),
        .ctl      (mac_ctl),
        .p_val    (p_val),
        .l_val    (s1_l_reg),
        .res_vld  (res_vld),
        .res_elem (res_elem),
        .res_val  (res_val)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (load)
            out_valid_reg <= 1'b1;
        else if (out_take)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_node_reg  <= node_reg;
            out_index_reg <= res_elem;
            out_value_reg <= res_val;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_node  = out_node_reg;
    assign out_index = out_index_reg;
    assign out_value = out_value_reg;
    assign out_last  = out_index_reg == LAST_ELEM;

    a_stall_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> state_reg != ST_IDLE)
        else $error("input held off while idle");

    a_idle_empty: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_IDLE |-> !s1_vld_reg)
        else $error("read in flight while idle");

    a_wb_self: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_WB |-> self_reg && !res_vld)
        else $error("write-back without self parent or with a result pending");

    a_last_done: assert property (@(posedge clk) disable iff (!rst_n)
        (load && res_elem == LAST_ELEM) |=> state_reg == ST_IDLE || state_reg == ST_WB)
        else $error("compute not closed after last element");

endmodule
